// ===== rtl/sha1_pkg.sv =====
// Shared types, constants and the round-constant function of the SHA-1 hash engine.
`default_nettype none

package sha1_pkg;

    localparam int FILL_W = 7;
    localparam int ROUND_W = 7;

    localparam logic [FILL_W-1:0] FILL_FULL = 7'd64;
    localparam logic [FILL_W-1:0] FILL_LAST_DATA = 7'd63;
    localparam logic [FILL_W-1:0] FILL_LEN_POS = 7'd56;
    localparam logic [FILL_W-1:0] FILL_ONE = 7'd1;
    localparam logic [FILL_W-1:0] FILL_LEN_BYTES = 7'd8;

    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [ROUND_W-1:0] ROUND_ONE = 7'd1;
    localparam logic [ROUND_W-1:0] ROUND_P1 = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_P2 = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_P3 = 7'd60;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [63:0] LEN_STEP = 64'd8;

    localparam logic [31:0] INIT_H0 = 32'h67452301;
    localparam logic [31:0] INIT_H1 = 32'hefcdab89;
    localparam logic [31:0] INIT_H2 = 32'h98badcfe;
    localparam logic [31:0] INIT_H3 = 32'h10325476;
    localparam logic [31:0] INIT_H4 = 32'hc3d2e1f0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_FINISH
    } sha1_state_t;

    typedef enum logic [1:0] {
        PHASE_CH,
        PHASE_PAR1,
        PHASE_MAJ,
        PHASE_PAR2
    } round_phase_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO
    } byte_src_t;

    typedef struct packed {
        logic         shift_byte;
        byte_src_t    byte_src;
        logic         count_byte;
        logic         shift_len;
        logic         load_work;
        logic         do_round;
        round_phase_t phase;
        logic         update_chain;
        logic         emit;
    } sha1_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              out_free;
    } sha1_status_t;

    function automatic logic [31:0] round_const(input round_phase_t phase);
        logic [31:0] k;
        case (phase)
            PHASE_CH:   k = 32'h5a827999;
            PHASE_PAR1: k = 32'h6ed9eba1;
            PHASE_MAJ:  k = 32'h8f1bbcdc;
            PHASE_PAR2: k = 32'hca62c1d6;
            default:    k = 32'hca62c1d6;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sha1_ctrl.sv =====
// Controller state machine of the SHA-1 hash engine.
`default_nettype none

module sha1_ctrl
    import sha1_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         has_byte,
    input  wire logic         is_last,
    input  wire sha1_status_t status,
    output logic              in_stall,
    output sha1_cmd_t         cmd
);

    sha1_state_t state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic last_reg, last_next;
    logic pad_reg, pad_next;
    logic final_reg, final_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            last_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            last_reg  <= last_next;
            pad_reg   <= pad_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        last_next  = last_reg;
        pad_next   = pad_reg;
        final_next = final_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte && status.fill == FILL_LAST_DATA)
                    begin
                        state_next = ST_LOAD;
                        last_next  = is_last;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                pad_next   = 1'b1;
                last_next  = 1'b0;
                state_next = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (status.fill == FILL_LEN_POS)
                begin
                    final_next = 1'b1;
                    state_next = ST_LOAD;
                end
                else if (status.fill == FILL_FULL)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                round_next = round_reg + ROUND_ONE;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (final_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD_ZERO;
                end
                else if (last_reg)
                begin
                    state_next = ST_PAD_MARK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    last_next  = 1'b0;
                    pad_next   = 1'b0;
                    final_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.byte_src = SRC_ZERO;
        cmd.phase    = PHASE_CH;
        in_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && has_byte)
                begin
                    cmd.shift_byte = 1'b1;
                    cmd.byte_src   = SRC_DATA;
                    cmd.count_byte = 1'b1;
                end
            end
            ST_PAD_MARK:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_src   = SRC_MARK;
            end
            ST_PAD_ZERO:
            begin
                if (status.fill == FILL_LEN_POS)
                begin
                    cmd.shift_len = 1'b1;
                end
                else if (status.fill != FILL_FULL)
                begin
                    cmd.shift_byte = 1'b1;
                end
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (round_reg < ROUND_P1)
                begin
                    cmd.phase = PHASE_CH;
                end
                else if (round_reg < ROUND_P2)
                begin
                    cmd.phase = PHASE_PAR1;
                end
                else if (round_reg < ROUND_P3)
                begin
                    cmd.phase = PHASE_MAJ;
                end
                else
                begin
                    cmd.phase = PHASE_PAR2;
                end
            end
            ST_UPDATE:
            begin
                cmd.update_chain = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sha1_datapath.sv =====
// Datapath of the SHA-1 hash engine: block and schedule register, round unit, chaining words.
`default_nettype none

module sha1_datapath
    import sha1_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire sha1_cmd_t  cmd,
    input  wire logic       out_stall,
    output sha1_status_t    status,
    output logic            out_valid,
    output logic [31:0]     digest_h0,
    output logic [31:0]     digest_h1,
    output logic [31:0]     digest_h2,
    output logic [31:0]     digest_h3,
    output logic [31:0]     digest_h4
);

    logic [511:0] blk_reg, blk_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] h_reg [5];
    logic [31:0] h_next [5];
    logic [31:0] dig_reg [5];
    logic [31:0] dig_next [5];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic out_valid_reg, out_valid_next;

    logic [7:0] byte_in;
    logic [31:0] w0, w2, w8, w13, w_mix, w_new;
    logic [31:0] f_val, t_sum;

    assign w0    = blk_reg[511:480];
    assign w2    = blk_reg[447:416];
    assign w8    = blk_reg[255:224];
    assign w13   = blk_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        case (cmd.byte_src)
            SRC_DATA: byte_in = data_byte;
            SRC_MARK: byte_in = PAD_MARK;
            SRC_ZERO: byte_in = 8'h00;
            default:  byte_in = 8'h00;
        endcase
    end

    always_comb
    begin
        case (cmd.phase)
            PHASE_CH:   f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            PHASE_PAR1: f_val = b_reg ^ c_reg ^ d_reg;
            PHASE_MAJ:  f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            PHASE_PAR2: f_val = b_reg ^ c_reg ^ d_reg;
            default:    f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign t_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + w0 + round_const(cmd.phase);

    always_comb
    begin
        blk_next       = blk_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        h_next         = h_reg;
        dig_next       = dig_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.shift_byte)
        begin
            blk_next  = {blk_reg[503:0], byte_in};
            fill_next = fill_reg + FILL_ONE;
        end
        if (cmd.shift_len)
        begin
            blk_next  = {blk_reg[447:0], len_reg};
            fill_next = fill_reg + FILL_LEN_BYTES;
        end
        if (cmd.count_byte)
        begin
            len_next = len_reg + LEN_STEP;
        end
        if (cmd.load_work)
        begin
            fill_next = '0;
            a_next    = h_reg[0];
            b_next    = h_reg[1];
            c_next    = h_reg[2];
            d_next    = h_reg[3];
            e_next    = h_reg[4];
        end
        if (cmd.do_round)
        begin
            blk_next = {blk_reg[479:0], w_new};
            a_next   = t_sum;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
        end
        if (cmd.update_chain)
        begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end
        if (cmd.emit)
        begin
            dig_next       = h_reg;
            out_valid_next = 1'b1;
            h_next[0]      = INIT_H0;
            h_next[1]      = INIT_H1;
            h_next[2]      = INIT_H2;
            h_next[3]      = INIT_H3;
            h_next[4]      = INIT_H4;
            fill_next      = '0;
            len_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0]      <= INIT_H0;
            h_reg[1]      <= INIT_H1;
            h_reg[2]      <= INIT_H2;
            h_reg[3]      <= INIT_H3;
            h_reg[4]      <= INIT_H4;
            fill_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            h_reg         <= h_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        dig_reg <= dig_next;
    end

    assign status.fill     = fill_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign digest_h0       = dig_reg[0];
    assign digest_h1       = dig_reg[1];
    assign digest_h2       = dig_reg[2];
    assign digest_h3       = dig_reg[3];
    assign digest_h4       = dig_reg[4];

endmodule

`default_nettype wire

// ===== rtl/sha1_hash_engine.sv =====
// Top level of the SHA-1 hash engine.
// The engine takes one message item per cycle while it is idle; an item that completes a
// 64-byte block makes it busy for the work load, 80 rounds of the single round unit and
// the chaining update. An item marked last adds marker and zero bytes at one byte per
// cycle while no block is being compressed, then the 64-bit length; the padding fills one
// or two further blocks, and a finish step loads the digest register. The digest is held
// until taken, and the next message is accepted meanwhile; only a second digest waits for
// the first to leave.
`default_nettype none

module sha1_hash_engine
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_h0,
    output logic [31:0]      digest_h1,
    output logic [31:0]      digest_h2,
    output logic [31:0]      digest_h3,
    output logic [31:0]      digest_h4
);

    sha1_cmd_t    cmd;
    sha1_status_t status;

    sha1_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .has_byte (has_byte),
        .is_last  (is_last),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    sha1_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .cmd       (cmd),
        .out_stall (out_stall),
        .status    (status),
        .out_valid (out_valid),
        .digest_h0 (digest_h0),
        .digest_h1 (digest_h1),
        .digest_h2 (digest_h2),
        .digest_h3 (digest_h3),
        .digest_h4 (digest_h4)
    );

endmodule

`default_nettype wire

// ===== rtl/sha1_checker.sv =====
// Port-level assertions for the SHA-1 hash engine and their binding.
`default_nettype none

module sha1_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        has_byte,
    input wire logic        is_last,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] digest_h0,
    input wire logic [31:0] digest_h1,
    input wire logic [31:0] digest_h2,
    input wire logic [31:0] digest_h3,
    input wire logic [31:0] digest_h4
);

    logic [159:0] digest_all;
    assign digest_all = {digest_h0, digest_h1, digest_h2, digest_h3, digest_h4};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_all))
        else $error("Stalled digest item changed or vanished.");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && is_last |=> in_stall)
        else $error("Engine idle right after a last item.");

    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !has_byte && !is_last |=> !in_stall)
        else $error("Empty item made the engine busy.");

    a_digest_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("Digest item appeared while the engine was idle.");

endmodule

bind sha1_hash_engine sha1_checker u_checker (.*);

`default_nettype wire
